// ===== rtl/core/dpfr_pkg.sv =====
// shared types and constants for the demand page fault resolver
package dpfr_pkg;

   localparam int SEGMENTS          = 8;
   localparam int PAGES_PER_SEGMENT = 256;
   localparam int SEG_IDX_W         = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int PAGE_IDX_W        = (PAGES_PER_SEGMENT > 1) ? $clog2(PAGES_PER_SEGMENT) : 1;

   localparam int ADDR_W    = 32;
   localparam int PERM_W    = 3;
   localparam int INDEX_W   = 3;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 4;
   localparam int SHIFT_W   = 5;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd10;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEGMENT_COUNT = 2'd0,
      CSR_PAGE_SHIFT    = 2'd1
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NOT_MAPPED   = 2'd0,
      KIND_ACCESS_ERROR = 2'd1,
      KIND_OTHER        = 2'd2,
      KIND_OTHER_ALT    = 2'd3
   } fault_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_MAP_PAGE       = 3'd0,
      STATUS_FATAL_ACCESS   = 3'd1,
      STATUS_FATAL_NO_SEG   = 3'd2,
      STATUS_FATAL_MAPPED   = 3'd3,
      STATUS_FATAL_BEYOND   = 3'd4,
      STATUS_IGNORED        = 3'd5,
      STATUS_ENTRY_WRITTEN  = 3'd6
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] file_offset;
      logic [PERM_W-1:0] permission;
   } seg_entry_type;

   typedef struct packed {
      logic                  hit;
      logic                  beyond;
      logic [PAGE_IDX_W-1:0] page;
      logic [ADDR_W-1:0]     delta;
   } match_type;

endpackage

// ===== rtl/core/dpfr_seg_table.sv =====
// segment table storage with one write port and a registered read port
module dpfr_seg_table
   import dpfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SEG_IDX_W-1:0] wr_idx,
   input  seg_entry_type        wr_entry,
   input  logic [SEG_IDX_W-1:0] rd_idx,
   output seg_entry_type        rd_entry
);

   seg_entry_type table_mem [SEGMENTS];
   seg_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_idx] <= wr_entry;
      end
      rd_entry_ff <= table_mem[rd_idx];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== rtl/core/dpfr_page_bitmap.sv =====
// mapped-page bitmap, one row of page bits per segment, registered row read
module dpfr_page_bitmap
   import dpfr_pkg::*;
(
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [SEG_IDX_W-1:0]         wr_idx,
   input  logic [PAGES_PER_SEGMENT-1:0] wr_row,
   input  logic [SEG_IDX_W-1:0]         rd_idx,
   output logic [PAGES_PER_SEGMENT-1:0] rd_row
);

   logic [PAGES_PER_SEGMENT-1:0] row_mem [SEGMENTS];
   logic [PAGES_PER_SEGMENT-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_idx] <= wr_row;
      end
      rd_row_ff <= row_mem[rd_idx];
   end

   assign rd_row = rd_row_ff;

endmodule

// ===== rtl/core/dpfr_match_unit.sv =====
// shared range compare, offset subtract and page shift for one segment entry
module dpfr_match_unit
   import dpfr_pkg::*;
(
   input  logic [ADDR_W-1:0]  address,
   input  seg_entry_type      entry,
   input  logic [SHIFT_W-1:0] shift,
   output match_type          result
);

   logic [ADDR_W:0]   limit;
   logic [ADDR_W-1:0] offset;
   logic [ADDR_W-1:0] page_full;
   logic [ADDR_W-1:0] mask;

   always_comb begin
      // end of segment taken without wrap
      limit     = {1'b0, entry.base} + {1'b0, entry.length};
      offset    = address - entry.base;
      page_full = offset >> shift;
      mask      = {ADDR_W{1'b1}} << shift;
      result.hit    = (address >= entry.base) && ({1'b0, address} < limit);
      result.beyond = (page_full >= ADDR_W'(PAGES_PER_SEGMENT));
      result.page   = page_full[PAGE_IDX_W-1:0];
      result.delta  = offset & mask;
   end

endmodule

// ===== rtl/core/demand_page_fault_resolver_top.sv =====
// demand page fault resolver: sequencer, request decode and result register
//
// Requests enter on req_ (tvalid/tready/tdata/tuser); tuser is the action bit,
// 0 loads one segment table entry, 1 resolves a fault. Results leave on rsp_
// with the status code in tuser. csr_ writes segment_count (index 0) and
// page_shift (index 1). They must be written only while the block is idle;
// the block itself does not enforce this. A table write stores the entry and
// a cleared row of mapped bits in the accept cycle. A fault that is fatal or
// ignored by kind goes straight to its result. A not-mapped fault scans the
// table one entry per cycle through a single compare and shift unit and stops
// at the first segment that holds the address, at most 8 entries and none
// when no segment is in use; unless the page lies past the bitmap, the row
// of mapped bits is then read and the page's bit set if it was clear.
// One request is in work at a time; req_tready is high only when the
// sequencer is idle. A finished result waits in a holding register if the
// output register is still full, so a stalled receiver holds rsp_ steady and
// back-pressures new requests without losing anything.
// Reset clears the control state, the CSRs and the output valid; the table and bitmap
// need no clearing pass since a segment row is cleared when it is written.
module demand_page_fault_resolver_top
   import dpfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // entry_index, entry_base, entry_length, entry_file_offset,
   // entry_permission, fault_address, fault_kind
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // action
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // page_address, page_file_offset, page_permission, hit_segment, zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic [STATUS_W-1:0]    rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      IDLE,
      CHECK,
      MARK,
      FINISH
   } state_type;

   // request fields
   logic [INDEX_W-1:0] req_index;
   seg_entry_type      req_entry;
   logic [ADDR_W-1:0]  req_address;
   fault_kind_type     req_kind;

   assign req_index              = req_tdata[2:0];
   assign req_entry.base         = req_tdata[34:3];
   assign req_entry.length       = req_tdata[66:35];
   assign req_entry.file_offset  = req_tdata[98:67];
   assign req_entry.permission   = req_tdata[101:99];
   assign req_address            = req_tdata[133:102];
   assign req_kind               = fault_kind_type'(req_tdata[135:134]);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] seg_count_ff, seg_count_in;
   logic [SHIFT_W-1:0] page_shift_ff, page_shift_in;
   logic [COUNT_W-1:0] scan_count_ff, scan_count_in;
   logic [SHIFT_W-1:0] scan_shift_ff, scan_shift_in;
   logic [COUNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [ADDR_W-1:0]  address_ff, address_in;
   logic [ADDR_W-1:0]  hit_base_ff, hit_base_in;
   logic [ADDR_W-1:0]  hit_offset_ff, hit_offset_in;
   logic [ADDR_W-1:0]  hit_delta_ff, hit_delta_in;
   logic [PERM_W-1:0]  hit_perm_ff, hit_perm_in;
   logic [PAGE_IDX_W-1:0] hit_page_ff, hit_page_in;
   status_type         res_status_ff, res_status_in;
   logic [ADDR_W-1:0]  res_paddr_ff, res_paddr_in;
   logic [ADDR_W-1:0]  res_poff_ff, res_poff_in;
   logic [PERM_W-1:0]  res_perm_ff, res_perm_in;
   logic [INDEX_W-1:0] res_hit_ff, res_hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_paddr_ff, rsp_paddr_in;
   logic [ADDR_W-1:0]  rsp_poff_ff, rsp_poff_in;
   logic [PERM_W-1:0]  rsp_perm_ff, rsp_perm_in;
   logic [INDEX_W-1:0] rsp_hit_ff, rsp_hit_in;

   logic                         accept;
   logic                         tbl_we;
   logic [SEG_IDX_W-1:0]         tbl_rd_idx;
   seg_entry_type                tbl_rd_entry;
   logic                         bm_we;
   logic [SEG_IDX_W-1:0]         bm_wr_idx;
   logic [PAGES_PER_SEGMENT-1:0] bm_wr_row;
   logic [PAGES_PER_SEGMENT-1:0] bm_rd_row;
   match_type                    match;
   logic [COUNT_W-1:0]           eff_count;
   logic [SHIFT_W-1:0]           eff_shift;
   logic [COUNT_W-1:0]           scan_next;
   logic                         slot_valid;

   dpfr_seg_table u_seg_table (
      .clock    (clock),
      .wr_en    (tbl_we),
      .wr_idx   (req_index[SEG_IDX_W-1:0]),
      .wr_entry (req_entry),
      .rd_idx   (tbl_rd_idx),
      .rd_entry (tbl_rd_entry)
   );

   dpfr_page_bitmap u_page_bitmap (
      .clock  (clock),
      .wr_en  (bm_we),
      .wr_idx (bm_wr_idx),
      .wr_row (bm_wr_row),
      .rd_idx (scan_idx_ff[SEG_IDX_W-1:0]),
      .rd_row (bm_rd_row)
   );

   dpfr_match_unit u_match_unit (
      .address (address_ff),
      .entry   (tbl_rd_entry),
      .shift   (scan_shift_ff),
      .result  (match)
   );

   assign req_tready = (state_ff == IDLE);
   assign accept     = req_tvalid && req_tready;
   assign scan_next  = scan_idx_ff + COUNT_W'(1);
   assign slot_valid = ({1'b0, req_index} < COUNT_W'(SEGMENTS));
   assign tbl_we     = accept && !req_tuser && slot_valid;

   always_comb begin
      eff_count = (seg_count_ff > COUNT_W'(SEGMENTS)) ? COUNT_W'(SEGMENTS) : seg_count_ff;
      if (page_shift_ff < SHIFT_MIN) begin
         eff_shift = SHIFT_MIN;
      end else if (page_shift_ff > SHIFT_MAX) begin
         eff_shift = SHIFT_MAX;
      end else begin
         eff_shift = page_shift_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      seg_count_in  = seg_count_ff;
      page_shift_in = page_shift_ff;
      scan_count_in = scan_count_ff;
      scan_shift_in = scan_shift_ff;
      scan_idx_in   = scan_idx_ff;
      address_in    = address_ff;
      hit_base_in   = hit_base_ff;
      hit_offset_in = hit_offset_ff;
      hit_delta_in  = hit_delta_ff;
      hit_perm_in   = hit_perm_ff;
      hit_page_in   = hit_page_ff;
      res_status_in = res_status_ff;
      res_paddr_in  = res_paddr_ff;
      res_poff_in   = res_poff_ff;
      res_perm_in   = res_perm_ff;
      res_hit_in    = res_hit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_paddr_in  = rsp_paddr_ff;
      rsp_poff_in   = rsp_poff_ff;
      rsp_perm_in   = rsp_perm_ff;
      rsp_hit_in    = rsp_hit_ff;
      tbl_rd_idx    = '0;
      bm_we         = 1'b0;
      bm_wr_idx     = req_index[SEG_IDX_W-1:0];
      bm_wr_row     = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_SEGMENT_COUNT: seg_count_in  = csr_wdata[COUNT_W-1:0];
            CSR_PAGE_SHIFT:    page_shift_in = csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (accept) begin
               res_paddr_in  = '0;
               res_poff_in   = '0;
               res_perm_in   = '0;
               res_hit_in    = '0;
               address_in    = req_address;
               scan_count_in = eff_count;
               scan_shift_in = eff_shift;
               scan_idx_in   = '0;
               state_in      = FINISH;
               if (!req_tuser) begin
                  // new segment entry starts with no pages mapped
                  bm_we         = slot_valid;
                  res_status_in = STATUS_ENTRY_WRITTEN;
                  res_hit_in    = req_index;
               end else if (req_kind == KIND_ACCESS_ERROR) begin
                  res_status_in = STATUS_FATAL_ACCESS;
               end else if (req_kind != KIND_NOT_MAPPED) begin
                  res_status_in = STATUS_IGNORED;
               end else if (eff_count == '0) begin
                  res_status_in = STATUS_FATAL_NO_SEG;
               end else begin
                  state_in = CHECK;
               end
            end
         end
         CHECK: begin
            if (match.hit) begin
               res_hit_in    = scan_idx_ff[INDEX_W-1:0];
               hit_base_in   = tbl_rd_entry.base;
               hit_offset_in = tbl_rd_entry.file_offset;
               hit_perm_in   = tbl_rd_entry.permission;
               hit_delta_in  = match.delta;
               hit_page_in   = match.page;
               if (match.beyond) begin
                  res_status_in = STATUS_FATAL_BEYOND;
                  state_in      = FINISH;
               end else begin
                  state_in = MARK;
               end
            end else if (scan_next == scan_count_ff) begin
               res_status_in = STATUS_FATAL_NO_SEG;
               state_in      = FINISH;
            end else begin
               scan_idx_in = scan_next;
               tbl_rd_idx  = scan_next[SEG_IDX_W-1:0];
            end
         end
         MARK: begin
            if (bm_rd_row[hit_page_ff]) begin
               res_status_in = STATUS_FATAL_MAPPED;
            end else begin
               res_status_in = STATUS_MAP_PAGE;
               res_paddr_in  = hit_base_ff + hit_delta_ff;
               res_poff_in   = hit_offset_ff + hit_delta_ff;
               res_perm_in   = hit_perm_ff;
               bm_we         = 1'b1;
               bm_wr_idx     = scan_idx_ff[SEG_IDX_W-1:0];
               bm_wr_row     = bm_rd_row | (PAGES_PER_SEGMENT'(1) << hit_page_ff);
            end
            state_in = FINISH;
         end
         FINISH: begin
            // hand over once the output register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_paddr_in  = res_paddr_ff;
               rsp_poff_in   = res_poff_ff;
               rsp_perm_in   = res_perm_ff;
               rsp_hit_in    = res_hit_ff;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         seg_count_ff  <= '0;
         page_shift_ff <= SHIFT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seg_count_ff  <= seg_count_in;
         page_shift_ff <= page_shift_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_count_ff <= scan_count_in;
      scan_shift_ff <= scan_shift_in;
      scan_idx_ff   <= scan_idx_in;
      address_ff    <= address_in;
      hit_base_ff   <= hit_base_in;
      hit_offset_ff <= hit_offset_in;
      hit_delta_ff  <= hit_delta_in;
      hit_perm_ff   <= hit_perm_in;
      hit_page_ff   <= hit_page_in;
      res_status_ff <= res_status_in;
      res_paddr_ff  <= res_paddr_in;
      res_poff_ff   <= res_poff_in;
      res_perm_ff   <= res_perm_in;
      res_hit_ff    <= res_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_paddr_ff  <= rsp_paddr_in;
      rsp_poff_ff   <= rsp_poff_in;
      rsp_perm_ff   <= rsp_perm_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_hit_ff, rsp_perm_ff, rsp_poff_ff, rsp_paddr_ff};

endmodule
